### src/dbds_pkg.sv
// Shared constants, codes and control types of the double-buffered digest set.
package dbds_pkg;

   // Geometry of the two banks.
   localparam int BUCKETS     = 256;
   localparam int WAYS        = 4;
   localparam int DIGEST_BITS = 128;

   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W   = $clog2(WAYS + 1);
   localparam int LOW_W    = DIGEST_BITS - 64;
   localparam int FADDR_W  = BUCKET_W + 1;
   localparam int DADDR_W  = FADDR_W + WAY_W;
   localparam int TOTAL_W  = 11;
   localparam int LIMIT_W  = 11;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(30);
   localparam logic [FILL_W-1:0]  WAYS_FILL   = FILL_W'(WAYS);

   // Operation codes of a request beat.
   localparam logic [2:0] OP_INSERT     = 3'd0;
   localparam logic [2:0] OP_LOOKUP     = 3'd1;
   localparam logic [2:0] OP_SWAP       = 3'd2;
   localparam logic [2:0] OP_CLEAR_FILL = 3'd3;
   localparam logic [2:0] OP_CLEAR_BOTH = 3'd4;

   // Controller states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_INSERT,
      ST_SCAN,
      ST_SWAP,
      ST_CLR_FILL,
      ST_CLR_BOTH,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic ins_write;
      logic scan_issue;
      logic swap;
      logic clr_step;
      logic clr_all;
      logic clr_regs;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;
      logic match;
      logic last_fill;
      logic last_all;
      logic out_free;
   } status_type;

endpackage

### src/double_buffered_digest_set.sv
// Each item runs from idle through its op state and the finish state before the next is taken.
// Lookup scans the filled slots of the query bucket (at most WAYS) in its op state,
// as the digest store is read one slot a cycle and the scan stops at the first hit.
// Clearing the fill bank sweeps 256 counters and clearing both banks 512 (one counter a cycle).
// Reset is synchronous; afterwards a pass zeroes all 512 bucket counters, req_ready low.
// The result register lets the next request beat in while a result waits for rsp_ready.
module double_buffered_digest_set (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_op,
   input  logic [63:0]                  req_digest_high,
   input  logic [63:0]                  req_digest_low,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic                         rsp_insert_ok,
   output logic                         rsp_over_limit,
   output logic                         rsp_received,
   output logic                         rsp_filling_bank,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dbds_pkg::LIMIT_W-1:0] csr_entry_limit
);

   dbds_pkg::cmd_type    cmd;
   dbds_pkg::status_type status;

   // Sequencer.
   dbds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and result path.
   dbds_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_digest_high  (req_digest_high),
      .req_digest_low   (req_digest_low),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_entry_limit  (csr_entry_limit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_insert_ok    (rsp_insert_ok),
      .rsp_over_limit   (rsp_over_limit),
      .rsp_received     (rsp_received),
      .rsp_filling_bank (rsp_filling_bank),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

### src/dbds_datapath.sv
// Datapath of the digest set: bucket counters, digest store, totals and result register.
module dbds_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [2:0]                    req_op,
   input  logic [63:0]                   req_digest_high,
   input  logic [63:0]                   req_digest_low,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dbds_pkg::LIMIT_W-1:0]  csr_entry_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic                          rsp_insert_ok,
   output logic                          rsp_over_limit,
   output logic                          rsp_received,
   output logic                          rsp_filling_bank,
   input  dbds_pkg::cmd_type             cmd,
   output dbds_pkg::status_type          status
);

   logic [dbds_pkg::DIGEST_BITS-1:0] key_in, key_ff;
   logic [dbds_pkg::BUCKET_W-1:0]    bucket_in, bucket_ff;
   logic                             fill_sel_ff, received_ff;
   logic [dbds_pkg::TOTAL_W-1:0]     total0_ff, total1_ff, query_total;
   logic [dbds_pkg::LIMIT_W-1:0]     limit_ff;
   logic [dbds_pkg::FILL_W-1:0]      fill_n_ff, way_ff;
   logic                             pend_ff, found_ff, ins_ok_ff;
   logic [dbds_pkg::FADDR_W-1:0]     sweep_ff, fill_rd_addr, fill_wr_addr;
   logic                             fill_wr_en;
   logic [dbds_pkg::FILL_W-1:0]      fill_wr_data;
   logic [dbds_pkg::FILL_W-1:0]      fill_mem [2**dbds_pkg::FADDR_W];
   logic [dbds_pkg::DIGEST_BITS-1:0] dig_mem [2**dbds_pkg::DADDR_W];
   logic [dbds_pkg::DIGEST_BITS-1:0] dig_rd_ff;
   logic [dbds_pkg::DADDR_W-1:0]     dig_wr_addr, dig_rd_addr;
   logic                             has_room, lookup_op, equal, store_en;
   logic                             rsp_valid_ff, rsp_found_ff, rsp_insert_ok_ff;
   logic                             rsp_over_limit_ff, rsp_received_ff, rsp_filling_bank_ff;

   // Key and bucket of the incoming beat; the key holds the whole digest, the bucket bits 63..56 of its high half.
   assign key_in    = {req_digest_high, req_digest_low[63 -: dbds_pkg::LOW_W]};
   assign bucket_in = req_digest_high[56 +: dbds_pkg::BUCKET_W];
   assign lookup_op = (req_op == dbds_pkg::OP_LOOKUP);

   // The bucket counter is read as the beat is taken: query bank for a lookup.
   assign fill_rd_addr = {fill_sel_ff ^ lookup_op, bucket_in};
   assign has_room     = (fill_n_ff < dbds_pkg::WAYS_FILL);
   assign store_en     = cmd.ins_write && has_room;

   // Bucket counter write port: clearing sweep or insert.
   always_comb begin
      fill_wr_en   = 1'b0;
      fill_wr_addr = sweep_ff;
      fill_wr_data = '0;
      if (cmd.clr_step) begin
         fill_wr_en   = 1'b1;
         fill_wr_addr = cmd.clr_all ? sweep_ff
                                    : {fill_sel_ff, sweep_ff[dbds_pkg::BUCKET_W-1:0]};
      end else if (store_en) begin
         fill_wr_en   = 1'b1;
         fill_wr_addr = {fill_sel_ff, bucket_ff};
         fill_wr_data = fill_n_ff + dbds_pkg::FILL_W'(1);
      end
   end

   // Bucket counter memory with registered read.
   always_ff @(posedge clock) begin
      if (fill_wr_en) begin
         fill_mem[fill_wr_addr] <= fill_wr_data;
      end
      if (cmd.accept) begin
         fill_n_ff <= fill_mem[fill_rd_addr];
      end
   end

   // Digest store: slot n of the fill bucket is written, query slots read one a cycle.
   assign dig_wr_addr = {fill_sel_ff, bucket_ff, fill_n_ff[dbds_pkg::WAY_W-1:0]};
   assign dig_rd_addr = {~fill_sel_ff, bucket_ff, way_ff[dbds_pkg::WAY_W-1:0]};

   always_ff @(posedge clock) begin
      if (store_en) begin
         dig_mem[dig_wr_addr] <= key_ff;
      end
      if (cmd.scan_issue) begin
         dig_rd_ff <= dig_mem[dig_rd_addr];
      end
   end

   assign equal = (dig_rd_ff == key_ff);

   // Status towards the controller.
   assign status.more      = (way_ff < fill_n_ff);
   assign status.match     = pend_ff && equal;
   assign status.last_fill = &sweep_ff[dbds_pkg::BUCKET_W-1:0];
   assign status.last_all  = &sweep_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Bank selection, totals, flags, counters and the result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_sel_ff  <= 1'b1;
         received_ff  <= 1'b0;
         total0_ff    <= '0;
         total1_ff    <= '0;
         limit_ff     <= dbds_pkg::LIMIT_RESET;
         sweep_ff     <= '0;
         way_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_entry_limit;
         end
         if (cmd.accept) begin
            sweep_ff <= '0;
         end else if (cmd.clr_step) begin
            sweep_ff <= sweep_ff + dbds_pkg::FADDR_W'(1);
         end
         if (cmd.accept) begin
            way_ff <= '0;
         end else if (cmd.scan_issue) begin
            way_ff <= way_ff + dbds_pkg::FILL_W'(1);
         end
         pend_ff <= cmd.scan_issue;
         if (cmd.swap) begin
            fill_sel_ff <= ~fill_sel_ff;
         end
         if (cmd.clr_regs) begin
            received_ff <= 1'b0;
         end else if (cmd.ins_write) begin
            received_ff <= 1'b1;
         end
         if (cmd.clr_regs) begin
            if (cmd.clr_all || !fill_sel_ff) begin
               total0_ff <= '0;
            end
            if (cmd.clr_all || fill_sel_ff) begin
               total1_ff <= '0;
            end
         end else if (store_en) begin
            if (fill_sel_ff) begin
               total1_ff <= total1_ff + dbds_pkg::TOTAL_W'(1);
            end else begin
               total0_ff <= total0_ff + dbds_pkg::TOTAL_W'(1);
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The query bank is the one not being filled.
   assign query_total = fill_sel_ff ? total0_ff : total1_ff;

   // Beat payload, per-item result flags and the result register.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff    <= key_in;
         bucket_ff <= bucket_in;
         found_ff  <= 1'b0;
         ins_ok_ff <= 1'b0;
      end
      if (cmd.ins_write) begin
         ins_ok_ff <= has_room;
      end
      if (status.match) begin
         found_ff <= 1'b1;
      end
      if (cmd.finish) begin
         rsp_found_ff        <= found_ff;
         rsp_insert_ok_ff    <= ins_ok_ff;
         rsp_over_limit_ff   <= (query_total > limit_ff);
         rsp_received_ff     <= received_ff;
         rsp_filling_bank_ff <= fill_sel_ff;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_insert_ok    = rsp_insert_ok_ff;
   assign rsp_over_limit   = rsp_over_limit_ff;
   assign rsp_received     = rsp_received_ff;
   assign rsp_filling_bank = rsp_filling_bank_ff;

   // A bucket counter read back never exceeds the number of slots.
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.accept) |-> (fill_n_ff <= dbds_pkg::WAYS_FILL))
      else $error("bucket counter above slot count");

   // Clearing both banks empties both totals and drops the received flag.
   a_clear_both: assert property (@(posedge clock) disable iff (reset)
      (cmd.clr_regs && cmd.clr_all) |=>
         (total0_ff == '0) && (total1_ff == '0) && !received_ff)
      else $error("clear of both banks left state behind");

   // A swap flips the fill bank.
   a_swap: assert property (@(posedge clock) disable iff (reset)
      cmd.swap |=> (fill_sel_ff != $past(fill_sel_ff)))
      else $error("swap did not change the fill bank");

   // A finished item is always presented.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not presented");

endmodule

### src/dbds_ctrl.sv
// Controller state machine of the digest set: sequences insert, lookup, swap and clears.
module dbds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_op,
   input  dbds_pkg::status_type status,
   output dbds_pkg::cmd_type    cmd
);

   dbds_pkg::state_type state_ff, state_in;

   // State register; reset starts the clearing pass over the bucket counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbds_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dbds_pkg::ST_INIT: begin
            if (status.last_all) begin
               state_in = dbds_pkg::ST_IDLE;
            end
         end
         dbds_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  dbds_pkg::OP_INSERT:     state_in = dbds_pkg::ST_INSERT;
                  dbds_pkg::OP_LOOKUP:     state_in = dbds_pkg::ST_SCAN;
                  dbds_pkg::OP_SWAP:       state_in = dbds_pkg::ST_SWAP;
                  dbds_pkg::OP_CLEAR_FILL: state_in = dbds_pkg::ST_CLR_FILL;
                  dbds_pkg::OP_CLEAR_BOTH: state_in = dbds_pkg::ST_CLR_BOTH;
                  default:                 state_in = dbds_pkg::ST_FINISH;
               endcase
            end
         end
         dbds_pkg::ST_INSERT: state_in = dbds_pkg::ST_FINISH;
         dbds_pkg::ST_SCAN: begin
            // Leave on a hit or once the last filled slot has been compared.
            if (status.match || !status.more) begin
               state_in = dbds_pkg::ST_FINISH;
            end
         end
         dbds_pkg::ST_SWAP: state_in = dbds_pkg::ST_FINISH;
         dbds_pkg::ST_CLR_FILL: begin
            if (status.last_fill) begin
               state_in = dbds_pkg::ST_FINISH;
            end
         end
         dbds_pkg::ST_CLR_BOTH: begin
            if (status.last_all) begin
               state_in = dbds_pkg::ST_FINISH;
            end
         end
         dbds_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = dbds_pkg::ST_IDLE;
            end
         end
         default: state_in = dbds_pkg::ST_INIT;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         dbds_pkg::ST_INIT: begin
            cmd.clr_step = 1'b1;
            cmd.clr_all  = 1'b1;
         end
         dbds_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         dbds_pkg::ST_INSERT: cmd.ins_write = 1'b1;
         dbds_pkg::ST_SCAN:   cmd.scan_issue = status.more && !status.match;
         dbds_pkg::ST_SWAP:   cmd.swap = 1'b1;
         dbds_pkg::ST_CLR_FILL: begin
            cmd.clr_step = 1'b1;
            cmd.clr_regs = status.last_fill;
         end
         dbds_pkg::ST_CLR_BOTH: begin
            cmd.clr_step = 1'b1;
            cmd.clr_all  = 1'b1;
            cmd.clr_regs = status.last_all;
         end
         dbds_pkg::ST_FINISH: cmd.finish = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule
